### rtl/bpm_pkg.sv
// Package for the byte pattern matcher: sizes, config register indexes,
// and the result record handed to the output stage. No dependencies.
package bpm_pkg;

    localparam int MAX_PATTERN_BYTES = 32;   // window depth, cells in the chain
    localparam int PATTERN_REG_BYTES = 32;   // bytes held by the pattern registers
    localparam int PATTERN_WORDS     = 4;
    localparam int BYTE_W            = 8;
    localparam int LEN_W             = 6;
    localparam int HOLD_W            = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int POS_W             = 32;
    localparam int TOTAL_W           = 32;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 3'd0,
        CFG_BYTES_0_7      = 3'd1,
        CFG_BYTES_8_15     = 3'd2,
        CFG_BYTES_16_23    = 3'd3,
        CFG_BYTES_24_31    = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic               hit;
        logic [POS_W-1:0]   offset;
        logic [TOTAL_W-1:0] total;
    } t_result;

endpackage

### rtl/bpm_cell.sv
// One window cell: holds one recent byte and its valid bit, shifts to its
// neighbor per transaction, compares the incoming byte. Uses bpm_pkg.
module bpm_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_shift,
    input  logic                      i_clear,
    input  logic [bpm_pkg::BYTE_W-1:0] i_byte,
    input  logic                      i_valid,
    input  logic [bpm_pkg::BYTE_W-1:0] i_pat_byte,
    input  logic                      i_in_use,
    output logic [bpm_pkg::BYTE_W-1:0] o_byte,
    output logic                      o_valid,
    output logic                      o_eq
);

    logic [bpm_pkg::BYTE_W-1:0] r_byte;
    logic                       r_valid;

    // unused positions always agree; used ones need a filled, equal byte
    assign o_eq    = ~i_in_use | (i_valid & (i_byte == i_pat_byte));
    assign o_byte  = r_byte;
    assign o_valid = r_valid & ~i_clear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

endmodule

### rtl/bpm_out_skid.sv
// Output register plus one skid entry for result records; decouples the
// input ready from the output ready. Uses bpm_pkg.
module bpm_out_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bpm_pkg::t_result i_result,
    output logic             o_can_push,
    output logic             o_valid,
    input  logic             i_ready,
    output bpm_pkg::t_result o_result
);

    logic             r_out_valid;
    logic             r_skid_valid;
    bpm_pkg::t_result r_out;
    bpm_pkg::t_result r_skid;

    assign o_can_push = ~r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_result   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || i_ready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_ready) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_valid || i_ready) begin
                r_out <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end
    end

endmodule

### rtl/byte_pattern_matcher.sv
// Top level of the byte pattern matcher: config registers, the chain of
// window cells, hold-off / position / total counters. Uses bpm_pkg,
// bpm_cell and bpm_out_skid.
//
// Exact, non-overlapping search for a pattern of 1..32 bytes in a stream of
// file bytes, one byte per input transaction, with exactly one result per
// input. The window is a chain of 32 cells; each cell keeps one recent byte
// and compares the byte arriving at it against the pattern byte aligned to
// its depth, so the whole window is checked in the cycle the byte is taken.
// Throughput is one byte per clock while the output keeps up. An accepted
// byte's result is registered into the output register, or, while a result
// waits there, into a one-entry skid behind it, so the input keeps taking
// bytes and drops ready only when both output entries are full. i_file_start
// restarts window, overlap hold-off and file offset on that byte; the match
// total runs across files and saturates at all ones. A match blocks further
// matches until its last byte has passed, so overlapping hits are dropped,
// leftmost first. pattern_length 0 or above 32 disables matching. Config
// writes take effect on the next cycle and are meant for idle periods.
module byte_pattern_matcher (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [bpm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bpm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input stream
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [bpm_pkg::BYTE_W-1:0]        i_data_byte,
    input  logic                              i_file_start,
    // result stream
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_match_hit,
    output logic [bpm_pkg::POS_W-1:0]         o_match_offset,
    output logic [bpm_pkg::TOTAL_W-1:0]       o_match_total
);

    localparam int NB = bpm_pkg::MAX_PATTERN_BYTES;
    localparam int BW = bpm_pkg::BYTE_W;

    // config registers
    logic [bpm_pkg::LEN_W-1:0]      r_pattern_length;
    logic [bpm_pkg::CFG_DATA_W-1:0] r_pattern_word [0:bpm_pkg::PATTERN_WORDS-1];

    // per-file and global counters
    logic [bpm_pkg::HOLD_W-1:0]  r_holdoff;
    logic [bpm_pkg::POS_W-1:0]   r_position;
    logic [bpm_pkg::TOTAL_W-1:0] r_total;
    logic [bpm_pkg::HOLD_W-1:0]  n_holdoff;
    logic [bpm_pkg::POS_W-1:0]   n_position;
    logic [bpm_pkg::TOTAL_W-1:0] n_total;

    logic                        accept;
    logic                        can_push;
    logic                        len_ok;
    logic                        window_eq;
    logic                        hit;
    logic [bpm_pkg::HOLD_W-1:0]  cur_holdoff;
    logic [bpm_pkg::POS_W-1:0]   cur_position;
    logic [bpm_pkg::HOLD_W-1:0]  len_m1;
    logic [15:0]                 shift_bits;
    logic [NB*BW-1:0]            pat_flat;
    logic [NB*BW-1:0]            pat_rev;
    logic [NB*BW-1:0]            pat_aligned;
    logic [BW-1:0]               win_byte  [0:NB-1];
    logic                        win_valid [0:NB-1];
    logic [NB-1:0]               cell_eq;
    bpm_pkg::t_result            result;
    bpm_pkg::t_result            out_result;

    assign accept     = i_in_valid & o_in_ready;
    assign o_in_ready = can_push;

    // ---- configuration writes ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= '0;
            for (int w = 0; w < bpm_pkg::PATTERN_WORDS; w++) begin
                r_pattern_word[w] <= '0;
            end
        end else if (i_cfg_we) begin
            case (bpm_pkg::t_cfg_index'(i_cfg_index))
                bpm_pkg::CFG_PATTERN_LENGTH: begin
                    r_pattern_length <= i_cfg_data[bpm_pkg::LEN_W-1:0];
                end
                bpm_pkg::CFG_BYTES_0_7:   r_pattern_word[0] <= i_cfg_data;
                bpm_pkg::CFG_BYTES_8_15:  r_pattern_word[1] <= i_cfg_data;
                bpm_pkg::CFG_BYTES_16_23: r_pattern_word[2] <= i_cfg_data;
                bpm_pkg::CFG_BYTES_24_31: r_pattern_word[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---- pattern alignment ----
    // Cell k must see pattern byte (len-1-k): reverse the byte order, then
    // shift down by (NB - len) bytes. Depends on config only.
    assign len_ok = (r_pattern_length != '0) &&
                    (32'(r_pattern_length) <= 32'(NB));
    assign shift_bits = (16'(NB) - 16'(r_pattern_length)) << 3;

    genvar g;
    generate
        for (g = 0; g < NB; g++) begin : g_pat
            if (g < bpm_pkg::PATTERN_REG_BYTES) begin : g_reg
                assign pat_flat[g*BW +: BW] = r_pattern_word[g / 8][(g % 8)*BW +: BW];
            end else begin : g_zero
                assign pat_flat[g*BW +: BW] = '0;
            end
            assign pat_rev[g*BW +: BW] = pat_flat[(NB-1-g)*BW +: BW];
        end
    endgenerate

    assign pat_aligned = pat_rev >> shift_bits;

    // ---- window cell chain ----
    // win_* is what arrives at each cell: cell 0 gets the new byte, cell k
    // gets cell k-1's stored byte, so win_* is the window after the shift.
    assign win_byte[0]  = i_data_byte;
    assign win_valid[0] = 1'b1;

    generate
        for (g = 0; g < NB; g++) begin : g_cell
            logic in_use;
            assign in_use = ({1'b0, r_pattern_length} > 7'(g));
            if (g < NB - 1) begin : g_link
                bpm_cell u_cell (
                    .i_clk      (i_clk),
                    .i_rst_n    (i_rst_n),
                    .i_shift    (accept),
                    .i_clear    (i_file_start),
                    .i_byte     (win_byte[g]),
                    .i_valid    (win_valid[g]),
                    .i_pat_byte (pat_aligned[g*BW +: BW]),
                    .i_in_use   (in_use),
                    .o_byte     (win_byte[g+1]),
                    .o_valid    (win_valid[g+1]),
                    .o_eq       (cell_eq[g])
                );
            end else begin : g_last
                bpm_cell u_cell (
                    .i_clk      (i_clk),
                    .i_rst_n    (i_rst_n),
                    .i_shift    (accept),
                    .i_clear    (i_file_start),
                    .i_byte     (win_byte[g]),
                    .i_valid    (win_valid[g]),
                    .i_pat_byte (pat_aligned[g*BW +: BW]),
                    .i_in_use   (in_use),
                    .o_byte     (),
                    .o_valid    (),
                    .o_eq       (cell_eq[g])
                );
            end
        end
    endgenerate

    assign window_eq = &cell_eq;

    // ---- match decision and counters ----
    assign cur_holdoff  = i_file_start ? '0 : r_holdoff;
    assign cur_position = i_file_start ? '0 : r_position;
    assign len_m1       = bpm_pkg::HOLD_W'(r_pattern_length - 1'b1);
    assign hit          = (cur_holdoff == '0) && len_ok && window_eq;

    always_comb begin
        n_position = cur_position + 1'b1;
        n_total    = r_total;
        if (cur_holdoff != '0) begin
            n_holdoff = cur_holdoff - 1'b1;
        end else if (hit) begin
            n_holdoff = len_m1;
        end else begin
            n_holdoff = '0;
        end
        if (hit && (r_total != '1)) begin
            n_total = r_total + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holdoff  <= '0;
            r_position <= '0;
            r_total    <= '0;
        end else if (accept) begin
            r_holdoff  <= n_holdoff;
            r_position <= n_position;
            r_total    <= n_total;
        end
    end

    assign result.hit    = hit;
    assign result.offset = hit ? (cur_position - bpm_pkg::POS_W'(len_m1)) : '0;
    assign result.total  = n_total;

    // ---- output stage ----
    bpm_out_skid u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_result   (result),
        .o_can_push (can_push),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_result   (out_result)
    );

    assign o_match_hit    = out_result.hit;
    assign o_match_offset = out_result.offset;
    assign o_match_total  = out_result.total;

`ifndef SYNTH
    // hold-off never exceeds the pattern span
    a_holdoff_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_holdoff) < 32'(NB)))
        else $error("overlap hold-off out of range");

    // two hits on consecutive bytes of one file need a one-byte pattern
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && hit && (r_pattern_length > 6'd1)) |=>
        !(accept && !i_file_start && hit))
        else $error("overlapping match reported");

    // the match total only grows
    a_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_total >= $past(r_total)))
        else $error("match total decreased");

    // input stalls only while a result waits at the output
    a_stall_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");
`endif

endmodule

### tb/byte_pattern_matcher_test.sv
// Self-checking testbench for byte_pattern_matcher: directed and random byte
// streams, randomized handshake gaps on both sides, results checked in order.
// Depends on bpm_pkg and the byte_pattern_matcher RTL.
`timescale 1ns / 1ps

module byte_pattern_matcher_test;

    localparam int CLK_HALF     = 4;        // 8 ns period
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_PCT     = 23;
    localparam int LONG_STALL   = 150;      // receiver hold-off, in cycles
    localparam int NUM_PHASES   = 18;
    localparam int PHASE_BYTES  = 80;

    // one byte of file data as queued for the driver
    typedef struct packed {
        logic [bpm_pkg::BYTE_W-1:0] value;
        logic                       first;
    } t_stream_byte;

    // pattern shapes used by the random phases
    typedef enum int {
        SHAPE_RANDOM,
        SHAPE_UNIFORM,
        SHAPE_PERIOD2
    } t_pattern_shape;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [bpm_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [bpm_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    logic [bpm_pkg::BYTE_W-1:0]     i_data_byte = '0;
    logic                           i_file_start = 1'b0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic                           o_match_hit;
    logic [bpm_pkg::POS_W-1:0]      o_match_offset;
    logic [bpm_pkg::TOTAL_W-1:0]    o_match_total;

    byte_pattern_matcher u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_file_start   (i_file_start),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_match_hit    (o_match_hit),
        .o_match_offset (o_match_offset),
        .o_match_total  (o_match_total)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow of the matcher: config registers plus search state.
    // ------------------------------------------------------------------
    logic [bpm_pkg::LEN_W-1:0]      cfg_len = '0;
    logic [bpm_pkg::CFG_DATA_W-1:0] cfg_words [bpm_pkg::PATTERN_WORDS] = '{default: '0};

    logic [bpm_pkg::BYTE_W-1:0]     recent [bpm_pkg::MAX_PATTERN_BYTES] = '{default: '0};
    int                             fill_count = 0;
    int                             holdoff_left = 0;
    logic [bpm_pkg::POS_W-1:0]      file_pos = '0;
    logic [bpm_pkg::TOTAL_W-1:0]    hit_total = '0;

    t_stream_byte                   byte_stream [$];        // waiting for the driver
    bpm_pkg::t_result               expected_results [$];   // waiting for the output side

    int                             cycle_count = 0;
    int                             mismatches = 0;
    int                             bytes_taken = 0;
    int                             hits_seen = 0;
    int                             configs_run = 0;
    int                             stall_asks = 0;
    int                             stall_taken = 0;
    int                             stall_left = 0;
    logic                           next_first = 1'b0;

    // No idling at all on either side while quiet is high.
    wire quiet = (cycle_count % 3000) < 500;

    // Advance the shadow by one byte and return the result it should produce.
    function automatic bpm_pkg::t_result scan_byte(
        logic [bpm_pkg::BYTE_W-1:0] value,
        logic                       first
    );
        bpm_pkg::t_result          res;
        logic [bpm_pkg::POS_W-1:0] at;
        logic                      same;
        int                        n;
        n = int'(cfg_len);
        res = '0;
        if (first) begin
            fill_count = 0;
            holdoff_left = 0;
            file_pos = '0;
        end
        for (int k = bpm_pkg::MAX_PATTERN_BYTES - 1; k > 0; k--)
            recent[k] = recent[k-1];
        recent[0] = value;
        if (fill_count < bpm_pkg::MAX_PATTERN_BYTES)
            fill_count++;
        at = file_pos;
        file_pos = file_pos + 1;

        if (holdoff_left > 0) begin
            holdoff_left--;
        end else if (n > 0 && n <= bpm_pkg::MAX_PATTERN_BYTES && fill_count >= n) begin
            // newest byte sits at recent[0], so pattern byte j is recent[n-1-j]
            same = 1'b1;
            for (int j = 0; j < n; j++)
                if (recent[n-1-j] != cfg_words[j/8][(j%8)*8 +: 8])
                    same = 1'b0;
            if (same) begin
                res.hit = 1'b1;
                res.offset = at - bpm_pkg::POS_W'(n - 1);
                holdoff_left = n - 1;
                if (hit_total != '1)
                    hit_total = hit_total + 1;
            end
        end
        res.total = hit_total;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: pops queued bytes, random gaps, holds until accepted.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_bytes
        t_stream_byte nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            // byte accepted at this edge: predict its result now
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(scan_byte(i_data_byte, i_file_start));
                bytes_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (byte_stream.size() != 0 &&
                    (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt = byte_stream.pop_front();
                    i_in_valid   <= 1'b1;
                    i_data_byte  <= nxt.value;
                    i_file_start <= nxt.first;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: random back-pressure plus an occasional long hold-off.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (stall_taken != stall_asks) begin
                stall_taken = stall_asks;
                stall_left = LONG_STALL;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Result monitor: in-order compare against the oldest prediction.
    always @(posedge i_clk) begin : check_results
        bpm_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing pending: hit=%0b offset=%0d total=%0d",
                       o_match_hit, o_match_offset, o_match_total);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (o_match_hit !== want.hit) begin
                    $error("match_hit: expected %0b, got %0b", want.hit, o_match_hit);
                    mismatches++;
                end
                if (o_match_offset !== want.offset) begin
                    $error("match_offset: expected %0d, got %0d",
                           want.offset, o_match_offset);
                    mismatches++;
                end
                if (o_match_total !== want.total) begin
                    $error("match_total: expected %0d, got %0d",
                           want.total, o_match_total);
                    mismatches++;
                end
                if (want.hit)
                    hits_seen++;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic cfg_write(bpm_pkg::t_cfg_index idx,
                             logic [bpm_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        // shadow follows at once; nothing is in flight while config changes
        case (idx)
            bpm_pkg::CFG_PATTERN_LENGTH: cfg_len = val[bpm_pkg::LEN_W-1:0];
            bpm_pkg::CFG_BYTES_0_7:      cfg_words[0] = val;
            bpm_pkg::CFG_BYTES_8_15:     cfg_words[1] = val;
            bpm_pkg::CFG_BYTES_16_23:    cfg_words[2] = val;
            bpm_pkg::CFG_BYTES_24_31:    cfg_words[3] = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sender pauses until every transaction has come back out.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (byte_stream.size() != 0 || i_in_valid || expected_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic push_byte(logic [bpm_pkg::BYTE_W-1:0] value);
        byte_stream.push_back('{value: value, first: next_first});
        next_first = 1'b0;
    endtask

    task automatic push_file_byte(logic [bpm_pkg::BYTE_W-1:0] value, logic first);
        next_first = first;
        push_byte(value);
    endtask

    // One random phase: fresh pattern, mostly pattern copies with random
    // corruption, file restarts and noise in between.
    task automatic random_phase(int len, t_pattern_shape shape, int nbytes, bit long_stall);
        logic [bpm_pkg::BYTE_W-1:0] pat [bpm_pkg::PATTERN_REG_BYTES];
        logic [bpm_pkg::BYTE_W-1:0] b0;
        logic [bpm_pkg::BYTE_W-1:0] b1;
        int                         made;
        int                         span;
        int                         roll;
        int                         bad_at;
        wait_drained();
        b0 = $urandom_range(3) == 0 ? 8'h00 : ($urandom_range(2) == 0 ? 8'hFF : 8'($urandom));
        b1 = 8'($urandom);
        for (int j = 0; j < bpm_pkg::PATTERN_REG_BYTES; j++) begin
            case (shape)
                SHAPE_UNIFORM: pat[j] = b0;
                SHAPE_PERIOD2: pat[j] = (j % 2 == 0) ? b0 : b1;
                default:       pat[j] = 8'($urandom);
            endcase
        end
        cfg_write(bpm_pkg::CFG_PATTERN_LENGTH, bpm_pkg::CFG_DATA_W'(len));
        for (int w = 0; w < bpm_pkg::PATTERN_WORDS; w++)
            cfg_write(bpm_pkg::t_cfg_index'(int'(bpm_pkg::CFG_BYTES_0_7) + w),
                      {pat[w*8+7], pat[w*8+6], pat[w*8+5], pat[w*8+4],
                       pat[w*8+3], pat[w*8+2], pat[w*8+1], pat[w*8]});
        configs_run++;
        @(negedge i_clk);

        // disabled lengths still get pattern-like traffic to prove no hit
        span = (len == 0) ? 8 :
               (len > bpm_pkg::MAX_PATTERN_BYTES ? bpm_pkg::MAX_PATTERN_BYTES : len);
        made = 0;
        next_first = 1'b1;
        while (made < nbytes) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                next_first = 1'b1;
            end else if (roll < 55) begin
                bad_at = ($urandom_range(99) < 15) ? $urandom_range(span - 1) : -1;
                for (int j = 0; j < span; j++) begin
                    push_byte(j == bad_at ? pat[j] ^ (8'h01 << $urandom_range(7)) : pat[j]);
                    made++;
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    push_byte($urandom_range(1) ? 8'($urandom)
                                                : pat[$urandom_range(span - 1)]);
                    made++;
                end
            end
        end
        // make the output side sit still while the sender keeps going
        if (long_stall)
            stall_asks++;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    int             phase_len [NUM_PHASES] =
        '{1, 2, 32, 0, 3, 8, 63, 16, 4, 31, 2, 33, 17, 5, 9, 24, 1, 32};

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset config has an empty pattern: nothing can match
        push_file_byte(8'h00, 1'b1);
        push_file_byte(8'h00, 1'b0);
        push_file_byte(8'hFF, 1'b0);
        wait_drained();

        // pattern 00 FF 00: self-overlapping, checks leftmost-first skip
        cfg_write(bpm_pkg::CFG_PATTERN_LENGTH, bpm_pkg::CFG_DATA_W'(3));
        cfg_write(bpm_pkg::CFG_BYTES_0_7, 64'h0000_0000_0000_FF00);
        configs_run++;
        @(negedge i_clk);
        push_file_byte(8'h00, 1'b1);
        push_byte(8'hFF); push_byte(8'h00);            // hit at offset 0
        push_byte(8'hFF); push_byte(8'h00);            // overlapping, dropped
        push_byte(8'hFF); push_byte(8'h00);            // hit at offset 4
        // partial match cut off by a new file
        push_byte(8'hFF); push_byte(8'h00); push_byte(8'hFF);
        push_file_byte(8'h00, 1'b1);                   // window restarts here
        push_byte(8'hFF); push_byte(8'h00);            // hit at offset 0
        // new file while the hold-off is still running
        push_file_byte(8'h00, 1'b1);
        push_byte(8'hFF); push_byte(8'h00);            // hit at offset 0
        push_byte(8'h5A); push_byte(8'hA5);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++)
            random_phase(phase_len[p], t_pattern_shape'(p % 3), PHASE_BYTES,
                         p == 2 || p == 10);

        wait_drained();
        repeat (16) @(posedge i_clk);

        $display("covered %0d bytes over %0d pattern settings (lengths 0 to 63)",
                 bytes_taken, configs_run);
        $display("%0d matches reported, %0d field mismatches", hits_seen, mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
